// ===== hdl/wpef_pkg.sv =====
package wpef_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 48;
    localparam int LIMB          = 32;
    // operand width of the multiply chain: all values are clamped to CAP = 2^62
    localparam int OPW           = 63;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [OPW-1:0]   CAP     = {1'b1, {(OPW-1){1'b0}}};
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    // register select is address bit 2
    localparam logic REG_SIGMA_SQ   = 1'b0;
    localparam logic REG_WELL_DEPTH = 1'b1;

endpackage

// ===== hdl/wpef_in_if.sv =====
interface wpef_in_if;
    import wpef_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] dist_sq;

    modport source (output valid, output dist_sq, input ready);
    modport sink   (input valid, input dist_sq, output ready);
endinterface

// ===== hdl/wpef_out_if.sv =====
interface wpef_out_if;
    import wpef_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] force_coef;
    logic                    saturated;

    modport source (output valid, output energy, output force_coef, output saturated,
                    input ready);
    modport sink   (input valid, input energy, input force_coef, input saturated,
                    output ready);
endinterface

// ===== hdl/wca_pair_energy_force.sv =====
// Pipeline: the divider (one quotient bit per stage), a chain of five multiplies, and the
// output register. Throughput: one item per cycle while the output is not stalled.
// A stall at the output holds every stage in place.
// Reset (synchronous, active low) empties the pipeline and sets sigma_sq and
// well_depth to 1.0.
module wca_pair_energy_force #(
    parameter int FRAC_BITS = wpef_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpef_pkg::APB_AW-1:0] paddr,
    input  logic [wpef_pkg::APB_DW-1:0] pwdata,
    output logic [wpef_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    wpef_in_if.sink                     i_in,
    wpef_out_if.source                  o_out
);
    import wpef_pkg::*;

    localparam int             DW   = IN_W + FRAC_BITS;
    localparam logic [OPW-1:0] ONE  = OPW'(1) << FRAC_BITS;
    localparam logic [OPW-1:0] HALF = OPW'(1) << (FRAC_BITS - 1);
    localparam logic [OPW-1:0] K4   = CAP / 63'd4;
    localparam logic [OPW-1:0] K48  = CAP / 63'd48;
    localparam logic [OPW:0]   NEG_MAG = (OPW+1)'(1) << (OUT_W - 1);

    logic [IN_W-1:0] r_sigma_sq;
    logic [IN_W-1:0] r_well_depth;
    logic            n_wr;
    logic            en;
    logic [OPW-1:0]  eps;

    // configuration port
    assign pready = 1'b1;
    assign n_wr   = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_WELL_DEPTH) ? r_well_depth : r_sigma_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_sq   <= IN_W'(1) << FRAC_BITS;
            r_well_depth <= IN_W'(1) << FRAC_BITS;
        end else if (n_wr) begin
            if (paddr[2] == REG_SIGMA_SQ) begin
                r_sigma_sq <= pwdata;
            end else begin
                r_well_depth <= pwdata;
            end
        end
    end

    assign eps = OPW'(r_well_depth);

    // whole pipeline advances unless the output register holds an untaken result
    logic r_out_vld;
    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // q = sigma_sq * 2^F / dist_sq
    logic          div_v, div_zero;
    logic [DW-1:0] div_q;

    wpef_div #(.FRAC_BITS(FRAC_BITS), .SBW(1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_num   ({r_sigma_sq, {FRAC_BITS{1'b0}}}),
        .i_den   (i_in.dist_sq),
        .i_sb    (i_in.dist_sq == '0),
        .o_valid (div_v),
        .o_quo   (div_q),
        .o_sb    (div_zero)
    );

    logic [63:0]    q64;
    logic [OPW-1:0] q_c;
    assign q64 = 64'(div_q);
    assign q_c = (q64 > {1'b0, CAP}) ? CAP : q64[OPW-1:0];

    // q^2, then q^3 = q6
    logic           m1_v, m1_zero;
    logic [OPW-1:0] m1_p, m1_q;

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(OPW+1)) u_mul_qq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (div_v), .i_a (q_c), .i_b (q_c), .i_sb ({q_c, div_zero}),
        .o_valid (m1_v), .o_p (m1_p), .o_sb ({m1_q, m1_zero})
    );

    logic           m2_v, m2_zero;
    logic [OPW-1:0] m2_p, m2_q;

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(OPW+1)) u_mul_q6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m1_v), .i_a (m1_p), .i_b (m1_q), .i_sb ({m1_q, m1_zero}),
        .o_valid (m2_v), .o_p (m2_p), .o_sb ({m2_q, m2_zero})
    );

    // eps*q6 and eps*q in parallel
    logic           m3a_v, m3b_v, m3_zero;
    logic [OPW-1:0] m3a_p, m3b_p, m3_q6;

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(OPW)) u_mul_eq6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m2_v), .i_a (eps), .i_b (m2_p), .i_sb (m2_p),
        .o_valid (m3a_v), .o_p (m3a_p), .o_sb (m3_q6)
    );

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(1)) u_mul_eq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m2_v), .i_a (eps), .i_b (m2_q), .i_sb (m2_zero),
        .o_valid (m3b_v), .o_p (m3b_p), .o_sb (m3_zero)
    );

    logic           ge_one, ge_half;
    logic [OPW-1:0] d_one, d_half;
    assign ge_one  = (m3_q6 >= ONE);
    assign ge_half = (m3_q6 >= HALF);
    assign d_one   = ge_one ? (m3_q6 - ONE) : (ONE - m3_q6);
    assign d_half  = ge_half ? (m3_q6 - HALF) : (HALF - m3_q6);

    // energy term and eps*q*q6
    logic           m4a_v, m4b_v, m4_ge_one, m4_ge_half, m4_zero;
    logic [OPW-1:0] m4a_p, m4b_p, m4_dh;

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(3)) u_mul_en (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m3a_v), .i_a (m3a_p), .i_b (d_one), .i_sb ({ge_one, ge_half, m3_zero}),
        .o_valid (m4a_v), .o_p (m4a_p), .o_sb ({m4_ge_one, m4_ge_half, m4_zero})
    );

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(OPW)) u_mul_t (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m3b_v), .i_a (m3b_p), .i_b (m3_q6), .i_sb (d_half),
        .o_valid (m4b_v), .o_p (m4b_p), .o_sb (m4_dh)
    );

    // force term
    logic           m5_v, m5_ge_one, m5_ge_half, m5_zero;
    logic [OPW-1:0] m5_p, m5_en;

    wpef_mul #(.FRAC_BITS(FRAC_BITS), .SBW(OPW+3)) u_mul_fo (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (m4a_v && m4b_v), .i_a (m4b_p), .i_b (m4_dh),
        .i_sb ({m4a_p, m4_ge_one, m4_ge_half, m4_zero}),
        .o_valid (m5_v), .o_p (m5_p), .o_sb ({m5_en, m5_ge_one, m5_ge_half, m5_zero})
    );

    // scale, combine, saturate
    logic [OPW-1:0]   t4, f_mag;
    logic [OPW:0]     e_val;
    logic             f_neg;
    logic [OUT_W-1:0] n_energy, n_force;
    logic             n_sat;

    assign t4    = (m5_en > K4) ? CAP : (m5_en << 2);
    assign f_mag = (m5_p > K48) ? CAP : ((m5_p << 5) + (m5_p << 4));
    assign f_neg = !m5_ge_half && (f_mag != '0);

    always_comb begin
        if (m5_ge_one) begin
            e_val = {1'b0, t4} + {1'b0, eps};
        end else if (t4 > eps) begin
            e_val = '0;
        end else begin
            e_val = {1'b0, eps - t4};
        end

        n_sat = 1'b0;
        if (e_val > (OPW+1)'(OUT_MAX)) begin
            n_energy = OUT_MAX;
            n_sat    = 1'b1;
        end else begin
            n_energy = e_val[OUT_W-1:0];
        end

        if (f_neg) begin
            if ({1'b0, f_mag} > NEG_MAG) begin
                n_force = {1'b1, {(OUT_W-1){1'b0}}};
                n_sat   = 1'b1;
            end else begin
                n_force = OUT_W'(0) - f_mag[OUT_W-1:0];
            end
        end else if ({1'b0, f_mag} > (OPW+1)'(OUT_MAX)) begin
            n_force = OUT_MAX;
            n_sat   = 1'b1;
        end else begin
            n_force = f_mag[OUT_W-1:0];
        end

        // zero distance overrides everything
        if (m5_zero) begin
            n_energy = OUT_MAX;
            n_force  = OUT_MAX;
            n_sat    = 1'b1;
        end
    end

    logic [OUT_W-1:0] r_energy, r_force;
    logic             r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= m5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_energy <= n_energy;
            r_force  <= n_force;
            r_sat    <= n_sat;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.energy     = r_energy;
    assign o_out.force_coef = r_force;
    assign o_out.saturated  = r_sat;

endmodule

// ===== hdl/wpef_div.sv =====
module wpef_div #(
    parameter int FRAC_BITS = wpef_pkg::FRAC_BITS_DEF,
    parameter int SBW       = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [wpef_pkg::IN_W+FRAC_BITS-1:0]  i_num,
    input  logic [wpef_pkg::IN_W-1:0]            i_den,
    input  logic [SBW-1:0]                       i_sb,
    output logic                                 o_valid,
    output logic [wpef_pkg::IN_W+FRAC_BITS-1:0]  o_quo,
    output logic [SBW-1:0]                       o_sb
);
    import wpef_pkg::*;

    localparam int DW = IN_W + FRAC_BITS;

    // restoring division, one quotient bit per stage; quotient shifts into r_num
    logic            r_vld [DW];
    logic [IN_W-1:0] r_rem [DW];
    logic [DW-1:0]   r_num [DW];
    logic [IN_W-1:0] r_den [DW];
    logic [SBW-1:0]  r_sb  [DW];

    logic            s_vld [DW];
    logic [IN_W-1:0] s_rem [DW];
    logic [DW-1:0]   s_num [DW];
    logic [IN_W-1:0] s_den [DW];
    logic [SBW-1:0]  s_sb  [DW];
    logic [IN_W:0]   s_trial [DW];
    logic            s_bit [DW];

    always_comb begin
        for (int k = 0; k < DW; k++) begin
            if (k == 0) begin
                s_vld[k] = i_valid;
                s_rem[k] = '0;
                s_num[k] = i_num;
                s_den[k] = i_den;
                s_sb[k]  = i_sb;
            end else begin
                s_vld[k] = r_vld[k-1];
                s_rem[k] = r_rem[k-1];
                s_num[k] = r_num[k-1];
                s_den[k] = r_den[k-1];
                s_sb[k]  = r_sb[k-1];
            end
            s_trial[k] = {s_rem[k], s_num[k][DW-1]};
            s_bit[k]   = (s_trial[k] >= {1'b0, s_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < DW; k++) r_vld[k] <= s_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DW; k++) begin
                r_rem[k] <= s_bit[k] ? IN_W'(s_trial[k] - {1'b0, s_den[k]})
                                     : s_trial[k][IN_W-1:0];
                r_num[k] <= {s_num[k][DW-2:0], s_bit[k]};
                r_den[k] <= s_den[k];
                r_sb[k]  <= s_sb[k];
            end
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_quo   = r_num[DW-1];
    assign o_sb    = r_sb[DW-1];

endmodule

// ===== hdl/wpef_mul.sv =====
module wpef_mul #(
    parameter int FRAC_BITS = wpef_pkg::FRAC_BITS_DEF,
    parameter int SBW       = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [wpef_pkg::OPW-1:0] i_a,
    input  logic [wpef_pkg::OPW-1:0] i_b,
    input  logic [SBW-1:0]           i_sb,
    output logic                     o_valid,
    output logic [wpef_pkg::OPW-1:0] o_p,
    output logic [SBW-1:0]           o_sb
);
    import wpef_pkg::*;

    // floor(a*b / 2^FRAC_BITS) clamped to CAP; three stages:
    // limb products, full sum, shift and clamp
    localparam int PW  = 2 * OPW;
    localparam int HIW = OPW - LIMB;

    logic [2*LIMB-1:0]    r_p00;
    logic [LIMB+HIW-1:0]  r_p01;
    logic [LIMB+HIW-1:0]  r_p10;
    logic [2*HIW-1:0]     r_p11;
    logic [PW-1:0]        r_prod;
    logic [OPW-1:0]       r_res;
    logic [2:0]           r_vld;
    logic [SBW-1:0]       r_sb1, r_sb2, r_sb3;

    logic [PW-1:0]        n_prod;
    logic [PW-1:0]        n_shift;
    logic                 n_over;

    assign n_prod = PW'(r_p00) + (PW'(r_p01) << LIMB) + (PW'(r_p10) << LIMB)
                  + (PW'(r_p11) << (2 * LIMB));
    assign n_shift = r_prod >> FRAC_BITS;
    assign n_over  = (|n_shift[PW-1:OPW]) | (n_shift[OPW-1] & (|n_shift[OPW-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= (2*LIMB)'(i_a[LIMB-1:0]) * (2*LIMB)'(i_b[LIMB-1:0]);
            r_p01  <= (LIMB+HIW)'(i_a[LIMB-1:0]) * (LIMB+HIW)'(i_b[OPW-1:LIMB]);
            r_p10  <= (LIMB+HIW)'(i_a[OPW-1:LIMB]) * (LIMB+HIW)'(i_b[LIMB-1:0]);
            r_p11  <= (2*HIW)'(i_a[OPW-1:LIMB]) * (2*HIW)'(i_b[OPW-1:LIMB]);
            r_sb1  <= i_sb;
            r_prod <= n_prod;
            r_sb2  <= r_sb1;
            r_res  <= n_over ? CAP : n_shift[OPW-1:0];
            r_sb3  <= r_sb2;
        end
    end

    assign o_valid = r_vld[2];
    assign o_p     = r_res;
    assign o_sb    = r_sb3;

endmodule
